// ----- rtl/core/ldq_pkg.sv -----
// package for the level ordered dedup queue: sizes, codes and shared types
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package ldq_pkg;

   localparam int DEPTH       = 64;
   localparam int LEVELS      = 16;
   localparam int VALUE_WIDTH = 16;

   localparam int LVL_W = $clog2(LEVELS);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // beat field widths
   localparam int FUNC_W   = 2;
   localparam int VAL_IN_W = 16;
   localparam int LEVEL_W  = 4;
   localparam int STAT_W   = 2;
   localparam int OUT_CNT_W = 7;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   typedef logic [FUNC_W-1:0] func_type;
   localparam func_type FUNC_PUSH  = 2'd0;
   localparam func_type FUNC_POP   = 2'd1;
   localparam func_type FUNC_QUERY = 2'd2;

   typedef logic [STAT_W-1:0] status_type;
   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_DUP   = 2'd1;
   localparam status_type STAT_FULL  = 2'd2;
   localparam status_type STAT_EMPTY = 2'd3;

   typedef enum logic {
      ST_IDLE,
      ST_HOLD
   } ctrl_state_type;

   typedef struct packed {
      logic exec;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

// ----- rtl/core/ldq_ctrl.sv -----
// controller for the level ordered dedup queue: output register state and handshakes
// depends on ldq_pkg
`timescale 1ns / 1ps
`default_nettype none

module ldq_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output ldq_pkg::ctrl_cmd_type cmd
);

   ldq_pkg::ctrl_state_type state_ff;
   ldq_pkg::ctrl_state_type state_in;
   logic                    accept;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ldq_pkg::ST_IDLE: begin
            if (accept) state_in = ldq_pkg::ST_HOLD;
         end
         ldq_pkg::ST_HOLD: begin
            if (rsp_tready && !accept) state_in = ldq_pkg::ST_IDLE;
         end
         default: state_in = ldq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ldq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         ldq_pkg::ST_HOLD: begin
            req_tready = rsp_tready;
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
            rsp_tvalid = 1'b0;
         end
      endcase
      cmd.exec = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ldq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/ldq_datapath.sv -----
// datapath for the level ordered dedup queue: shifting entry cells, level counts, result beat
// depends on ldq_pkg; driven by ldq_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module ldq_datapath (
   input  wire                                  clock,
   input  wire                                  reset,
   input  ldq_pkg::ctrl_cmd_type                cmd,
   input  wire  [ldq_pkg::FUNC_W-1:0]           func,
   input  wire  [ldq_pkg::VAL_IN_W-1:0]         value_in,
   input  wire  [ldq_pkg::LEVEL_W-1:0]          level,
   output logic [ldq_pkg::VAL_IN_W-1:0]         value_out,
   output logic [ldq_pkg::STAT_W-1:0]           status,
   output logic [ldq_pkg::OUT_CNT_W-1:0]        level_count,
   output logic [ldq_pkg::OUT_CNT_W-1:0]        occupancy
);

   localparam int DEPTH  = ldq_pkg::DEPTH;
   localparam int LEVELS = ldq_pkg::LEVELS;
   localparam int VW     = ldq_pkg::VALUE_WIDTH;
   localparam int LVL_W  = ldq_pkg::LVL_W;
   localparam int CNT_W  = ldq_pkg::CNT_W;

   logic [VW-1:0]     cell_val_ff [DEPTH];
   logic [VW-1:0]     cell_val_in [DEPTH];
   logic [LVL_W-1:0]  cell_lvl_ff [DEPTH];
   logic [LVL_W-1:0]  cell_lvl_in [DEPTH];
   logic [CNT_W-1:0]  cnt_ff [LEVELS];
   logic [CNT_W-1:0]  cnt_in [LEVELS];
   logic [CNT_W-1:0]  fill_ff;
   logic [CNT_W-1:0]  fill_in;

   logic [ldq_pkg::VAL_IN_W-1:0]  value_out_ff;
   logic [ldq_pkg::VAL_IN_W-1:0]  value_out_in;
   ldq_pkg::status_type           status_ff;
   ldq_pkg::status_type           status_in;
   logic [ldq_pkg::OUT_CNT_W-1:0] level_count_ff;
   logic [ldq_pkg::OUT_CNT_W-1:0] level_count_in;
   logic [ldq_pkg::OUT_CNT_W-1:0] occupancy_ff;
   logic [ldq_pkg::OUT_CNT_W-1:0] occupancy_in;

   logic [VW-1:0]     val;
   logic [LVL_W-1:0]  lv;
   logic [DEPTH-1:0]  occ;
   logic [DEPTH-1:0]  hit;
   logic [DEPTH-1:0]  lt_vec;
   logic [DEPTH-1:0]  ge_vec;
   logic [DEPTH-1:0]  lt_prev;
   logic [DEPTH-1:0]  ge_prev;
   logic [VW-1:0]     prev_val [DEPTH];
   logic [LVL_W-1:0]  prev_lvl [DEPTH];
   logic [VW-1:0]     next_val [DEPTH];
   logic [LVL_W-1:0]  next_lvl [DEPTH];
   logic              dup;
   logic              is_full;
   logic              is_empty;
   logic              push_ok;
   logic              pop_ok;

   // saturate level and mask value
   always_comb begin
      val = VW'(value_in);
      if (32'(level) >= 32'(LEVELS)) lv = LVL_W'(LEVELS - 1);
      else lv = LVL_W'(level);
   end

   // per cell compares
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         occ[i]    = (CNT_W'(i) < fill_ff);
         lt_vec[i] = occ[i] && (cell_lvl_ff[i] < lv);
         ge_vec[i] = occ[i] && (cell_lvl_ff[i] >= lv);
         hit[i]    = occ[i] && (cell_lvl_ff[i] <= lv) && (cell_val_ff[i] == val);
      end
      lt_prev = {lt_vec[DEPTH-2:0], 1'b1};
      ge_prev = {ge_vec[DEPTH-2:0], 1'b0};
      prev_val[0] = val;
      prev_lvl[0] = lv;
      for (int i = 1; i < DEPTH; i++) begin
         prev_val[i] = cell_val_ff[i-1];
         prev_lvl[i] = cell_lvl_ff[i-1];
      end
      for (int i = 0; i < DEPTH - 1; i++) begin
         next_val[i] = cell_val_ff[i+1];
         next_lvl[i] = cell_lvl_ff[i+1];
      end
      next_val[DEPTH-1] = cell_val_ff[DEPTH-1];
      next_lvl[DEPTH-1] = cell_lvl_ff[DEPTH-1];
   end

   assign dup      = |hit;
   assign is_full  = (fill_ff == CNT_W'(DEPTH));
   assign is_empty = (fill_ff == '0);
   assign push_ok  = cmd.exec && (func == ldq_pkg::FUNC_PUSH) && !dup && !is_full;
   assign pop_ok   = cmd.exec && (func == ldq_pkg::FUNC_POP) && !is_empty;

   // cell chain: insert before equal levels, shift up on pop
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_val_in[i] = cell_val_ff[i];
         cell_lvl_in[i] = cell_lvl_ff[i];
         if (push_ok) begin
            if (ge_prev[i]) begin
               cell_val_in[i] = prev_val[i];
               cell_lvl_in[i] = prev_lvl[i];
            end else if (lt_prev[i] && !lt_vec[i]) begin
               cell_val_in[i] = val;
               cell_lvl_in[i] = lv;
            end
         end else if (pop_ok) begin
            cell_val_in[i] = next_val[i];
            cell_lvl_in[i] = next_lvl[i];
         end
      end
   end

   // level counts and fill
   always_comb begin
      for (int j = 0; j < LEVELS; j++) begin
         cnt_in[j] = cnt_ff[j];
         if (push_ok && (LVL_W'(j) == lv)) cnt_in[j] = cnt_ff[j] + CNT_W'(1);
         if (pop_ok && (LVL_W'(j) == cell_lvl_ff[0])) cnt_in[j] = cnt_ff[j] - CNT_W'(1);
      end
      fill_in = fill_ff;
      if (push_ok) fill_in = fill_ff + CNT_W'(1);
      else if (pop_ok) fill_in = fill_ff - CNT_W'(1);
   end

   // result beat
   always_comb begin
      value_out_in = '0;
      status_in    = ldq_pkg::STAT_OK;
      case (func)
         ldq_pkg::FUNC_PUSH: begin
            if (dup) status_in = ldq_pkg::STAT_DUP;
            else if (is_full) status_in = ldq_pkg::STAT_FULL;
         end
         ldq_pkg::FUNC_POP: begin
            if (is_empty) status_in = ldq_pkg::STAT_EMPTY;
            else value_out_in = ldq_pkg::VAL_IN_W'(cell_val_ff[0]);
         end
         default: status_in = ldq_pkg::STAT_OK;
      endcase
      level_count_in = ldq_pkg::OUT_CNT_W'(cnt_in[lv]);
      occupancy_in   = ldq_pkg::OUT_CNT_W'(fill_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         for (int j = 0; j < LEVELS; j++) cnt_ff[j] <= '0;
      end else begin
         fill_ff <= fill_in;
         for (int j = 0; j < LEVELS; j++) cnt_ff[j] <= cnt_in[j];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_val_ff[i] <= cell_val_in[i];
         cell_lvl_ff[i] <= cell_lvl_in[i];
      end
      if (cmd.exec) begin
         value_out_ff   <= value_out_in;
         status_ff      <= status_in;
         level_count_ff <= level_count_in;
         occupancy_ff   <= occupancy_in;
      end
   end

   assign value_out   = value_out_ff;
   assign status      = status_ff;
   assign level_count = level_count_ff;
   assign occupancy   = occupancy_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   a_one_change: assert property (@(posedge clock) disable iff (reset)
      !(push_ok && pop_ok))
      else $error("push and pop in one beat");

   a_pop_fill: assert property (@(posedge clock) disable iff (reset)
      pop_ok |=> (fill_ff == $past(fill_ff) - CNT_W'(1)))
      else $error("pop did not lower fill count");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && (func == ldq_pkg::FUNC_POP) && is_empty)
      |=> (status_ff == ldq_pkg::STAT_EMPTY) && (value_out_ff == '0))
      else $error("pop on empty not reported");

endmodule

`default_nettype wire

// ----- rtl/core/level_ordered_dedup_queue_unit.sv -----
// level ordered dedup queue: a queue sorted by level that drops repeated values
//
// req beat: tuser is the operation (push, pop, query count), tdata the value and level.
// rsp beat: one per req beat; tuser is the status (ok, duplicate, full, empty),
// tdata the popped value, the count of the requested level and the total occupancy.
// a push is dropped as duplicate if the value is queued at its own or a lower level;
// otherwise it goes in behind all lower levels and ahead of queued entries of its level.
// a pop takes the head entry; a query only reports the count of one level.
// every operation is done in a shifting row of 64 cells that compare and move
// in parallel: the rsp beat appears in the cycle after the req beat, and a new
// req beat is taken every cycle while the receiver takes rsp beats.
// when the receiver stalls, the rsp beat is held and req_tready falls until it is taken.
// reset empties the queue and clears all level counts.
// depends on ldq_pkg, ldq_ctrl and ldq_datapath
`timescale 1ns / 1ps
`default_nettype none

module level_ordered_dedup_queue_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // value_in [15:0], level [19:16], zero [23:20]
   input  wire  [ldq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // func [1:0]
   input  wire  [ldq_pkg::FUNC_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // value_out [15:0], level_count [22:16], occupancy [29:23], zero [31:30]
   output logic [ldq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status [1:0]
   output logic [ldq_pkg::STAT_W-1:0]         rsp_tuser
);

   ldq_pkg::ctrl_cmd_type               cmd;
   logic [ldq_pkg::VAL_IN_W-1:0]        value_out;
   logic [ldq_pkg::STAT_W-1:0]          status;
   logic [ldq_pkg::OUT_CNT_W-1:0]       level_count;
   logic [ldq_pkg::OUT_CNT_W-1:0]       occupancy;

   ldq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ldq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .func        (req_tuser),
      .value_in    (req_tdata[15:0]),
      .level       (req_tdata[19:16]),
      .value_out   (value_out),
      .status      (status),
      .level_count (level_count),
      .occupancy   (occupancy)
   );

   assign rsp_tdata = {2'b00, occupancy, level_count, value_out};
   assign rsp_tuser = status;

endmodule

`default_nettype wire
